// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL top level.
// Plain text, no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sbfph_pkg.sv =====
// Types, codes and constants of the spectrum peak-hold / band flash block.
// No dependencies.
package sbfph_pkg;

  typedef struct packed {
    logic [7:0] magnitude;
    logic [4:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [4:0] bar_index;
    logic [7:0] bar_level;
    logic [7:0] bright_low;
    logic [7:0] bright_mid;
    logic [7:0] bright_high;
    logic [7:0] max_level_avg;
    logic       last;
  } out_item_t;

  // register indexes
  localparam logic [2:0] CFG_NOISE_THR    = 3'd0;
  localparam logic [2:0] CFG_BAR_DECAY    = 3'd1;
  localparam logic [2:0] CFG_BRIGHT_DECAY = 3'd2;
  localparam logic [2:0] CFG_BRIGHT_FLOOR = 3'd3;
  localparam logic [2:0] CFG_SLOW_W       = 3'd4;
  localparam logic [2:0] CFG_FAST_W       = 3'd5;
  localparam logic [2:0] CFG_FLASH_RATIO  = 3'd6;

  localparam logic [7:0]  RST_NOISE_THR    = 8'd50;
  localparam logic [7:0]  RST_BAR_DECAY    = 8'd2;
  localparam logic [7:0]  RST_BRIGHT_DECAY = 8'd10;
  localparam logic [7:0]  RST_BRIGHT_FLOOR = 8'd30;
  localparam logic [15:0] RST_SLOW_W       = 16'd393;
  localparam logic [15:0] RST_FAST_W       = 16'd52429;
  localparam logic [15:0] RST_FLASH_RATIO  = 16'd384;

  localparam logic       KIND_BAR     = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  localparam int unsigned NUM_BANDS = 3;
  localparam logic [4:0] FIRST_BAR_BIN = 5'd2;
  localparam logic [4:0] MID_START     = 5'd6;
  localparam logic [4:0] HIGH_START    = 5'd11;
  localparam logic [7:0] PEAK_FLOOR    = 8'd5;
  localparam logic [7:0] FLASH_LEVEL   = 8'd255;

  // shared multiplier widths
  localparam int unsigned MAC_A_W = 24;
  localparam int unsigned MAC_B_W = 17;
  localparam int unsigned PROD_W  = MAC_A_W + MAC_B_W;
  localparam int unsigned ACC_W   = PROD_W - 16;
  localparam int unsigned SUM_W   = ACC_W + 1;
  localparam logic [MAC_B_W-1:0] ONE_Q16    = 17'h10000;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 41'd32768;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIN,
    ST_EMA,
    ST_SUM
  } state_e;

  typedef enum logic [1:0] {
    JOB_PEAK_EMA,
    JOB_SLOW_EMA,
    JOB_FAST_EMA,
    JOB_FLASH
  } job_kind_e;

  typedef enum logic {
    ACC_HOLD,
    ACC_ROUND
  } acc_op_e;

  localparam int unsigned JOB_W = 4;
  localparam logic [JOB_W-1:0] JOB_LAST = 4'd9;
  localparam logic [1:0] PHASE_EMA_LAST   = 2'd2;
  localparam logic [1:0] PHASE_FLASH_LAST = 2'd1;

  typedef struct packed {
    job_kind_e  kind;
    logic [1:0] band;
  } job_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_e acc_op;
  } mac_op_t;

  typedef struct packed {
    logic             in_ready;
    logic             bin_en;
    logic             push_bar;
    logic             push_sum;
    logic             ema_en;
    logic [JOB_W-1:0] job;
    logic [1:0]       phase;
  } seq_ctrl_t;

  // frame-end job list: peak average, then per band slow, fast, flash test
  function automatic job_t job_decode(logic [JOB_W-1:0] job);
    job_t j;
    unique case (job)
      4'd0:    j = '{kind: JOB_PEAK_EMA, band: 2'd0};
      4'd1:    j = '{kind: JOB_SLOW_EMA, band: 2'd0};
      4'd2:    j = '{kind: JOB_FAST_EMA, band: 2'd0};
      4'd3:    j = '{kind: JOB_FLASH,    band: 2'd0};
      4'd4:    j = '{kind: JOB_SLOW_EMA, band: 2'd1};
      4'd5:    j = '{kind: JOB_FAST_EMA, band: 2'd1};
      4'd6:    j = '{kind: JOB_FLASH,    band: 2'd1};
      4'd7:    j = '{kind: JOB_SLOW_EMA, band: 2'd2};
      4'd8:    j = '{kind: JOB_FAST_EMA, band: 2'd2};
      4'd9:    j = '{kind: JOB_FLASH,    band: 2'd2};
      default: j = '{kind: JOB_FLASH,    band: 2'd2};
    endcase
    return j;
  endfunction

endpackage

// ===== hdl/sbfph_mac.sv =====
// Shared multiply / round unit for the frame-end averages and flash test.
// Depends on sbfph_pkg.
module sbfph_mac (
  input  logic                         clk_i,
  input  sbfph_pkg::mac_op_t           op_i,
  input  logic [sbfph_pkg::MAC_A_W-1:0] a_i,
  input  logic [sbfph_pkg::MAC_B_W-1:0] b_i,
  output logic [sbfph_pkg::PROD_W-1:0]  prod_o,
  output logic [sbfph_pkg::SUM_W-1:0]   sum_o
);

  logic [sbfph_pkg::PROD_W-1:0] prod_q;
  logic [sbfph_pkg::ACC_W-1:0]  acc_q, acc_d;
  logic [sbfph_pkg::PROD_W-1:0] rounded;

  assign rounded = prod_q + sbfph_pkg::ROUND_HALF;

  always_comb begin
    unique case (op_i.acc_op)
      sbfph_pkg::ACC_ROUND: acc_d = rounded[sbfph_pkg::PROD_W-1:16];
      sbfph_pkg::ACC_HOLD:  acc_d = acc_q;
      default:              acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (op_i.mul_en) begin
      prod_q <= sbfph_pkg::PROD_W'(a_i) * sbfph_pkg::PROD_W'(b_i);
    end
    acc_q <= acc_d;
  end

  assign prod_o = prod_q;
  assign sum_o  = sbfph_pkg::SUM_W'(acc_q) + sbfph_pkg::SUM_W'(prod_q[sbfph_pkg::ACC_W-1:0]);

endmodule

// ===== hdl/sbfph_seq.sv =====
// Sequencer: item intake, bin update slot, frame-end job list, summary push.
// Depends on sbfph_pkg.
module sbfph_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 slot_free_i,
  input  logic                 bin_low_i,
  input  logic                 bin_last_i,
  output sbfph_pkg::seq_ctrl_t ctrl_o
);

  sbfph_pkg::state_e state_q, state_d;
  logic [sbfph_pkg::JOB_W-1:0] job_q, job_d;
  logic [1:0] phase_q, phase_d;
  sbfph_pkg::job_t jd;
  logic step_done, job_done;

  assign jd        = sbfph_pkg::job_decode(job_q);
  assign step_done = (jd.kind == sbfph_pkg::JOB_FLASH) ?
                     (phase_q == sbfph_pkg::PHASE_FLASH_LAST) :
                     (phase_q == sbfph_pkg::PHASE_EMA_LAST);
  assign job_done  = step_done && (job_q == sbfph_pkg::JOB_LAST);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sbfph_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = sbfph_pkg::ST_BIN;
      end
      sbfph_pkg::ST_BIN: begin
        if (bin_low_i) begin
          state_d = sbfph_pkg::ST_IDLE;
        end else if (slot_free_i) begin
          state_d = bin_last_i ? sbfph_pkg::ST_EMA : sbfph_pkg::ST_IDLE;
        end
      end
      sbfph_pkg::ST_EMA: begin
        if (job_done) state_d = sbfph_pkg::ST_SUM;
      end
      sbfph_pkg::ST_SUM: begin
        if (slot_free_i) state_d = sbfph_pkg::ST_IDLE;
      end
      default: state_d = sbfph_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    job_d   = '0;
    phase_d = '0;
    if (state_q == sbfph_pkg::ST_EMA) begin
      if (step_done) begin
        job_d = job_q + 1'b1;
      end else begin
        job_d   = job_q;
        phase_d = phase_q + 1'b1;
      end
    end
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.job      = job_q;
    ctrl_o.phase    = phase_q;
    ctrl_o.in_ready = (state_q == sbfph_pkg::ST_IDLE);
    ctrl_o.bin_en   = (state_q == sbfph_pkg::ST_BIN) && (bin_low_i || slot_free_i);
    ctrl_o.push_bar = (state_q == sbfph_pkg::ST_BIN) && !bin_low_i && slot_free_i;
    ctrl_o.ema_en   = (state_q == sbfph_pkg::ST_EMA);
    ctrl_o.push_sum = (state_q == sbfph_pkg::ST_SUM) && slot_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbfph_pkg::ST_IDLE;
      job_q   <= '0;
      phase_q <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      phase_q <= phase_d;
    end
  end

endmodule

// ===== hdl/spectrum_band_flash_peak_hold.sv =====
// Top level: spectrum peak-hold bars, band peaks, frame-end averages and flash.
// Depends on sbfph_pkg, sbfph_seq, sbfph_mac and assert_macros.svh.
//
//  port group   direction  handshake                 payload
//  in           into       in_valid_i / in_stall_o   in_data_i  (in_item_t)
//  out          out of     out_valid_o / out_stall_i out_data_o (out_item_t)
//  cfg          into       cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// Bins 0 and 1 push no result; bins 2 to 31 each push a bar and may wait for
// the output register. After bin 31 the shared multiplier runs 27
// sequencer steps (3 for the peak average, 8 per band) before the summary.
// Reset clears all bars, peaks, averages and brightnesses and loads the
// register defaults. A stalled output holds the block only when a result
// must be pushed; an item is taken while a result still waits.
`include "assert_macros.svh"

module spectrum_band_flash_peak_hold #(
  parameter int unsigned NUM_BARS = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sbfph_pkg::in_item_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sbfph_pkg::out_item_t  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [15:0]           cfg_wdata_i
);

  localparam int unsigned BarIdxW = $clog2(NUM_BARS);
  localparam logic [4:0]  LastBin = 5'(NUM_BARS + 1);

  // config
  logic [7:0]  noise_thr_q, bar_decay_q, bright_decay_q, bright_floor_q;
  logic [15:0] slow_w_q, fast_w_q, flash_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_thr_q    <= sbfph_pkg::RST_NOISE_THR;
      bar_decay_q    <= sbfph_pkg::RST_BAR_DECAY;
      bright_decay_q <= sbfph_pkg::RST_BRIGHT_DECAY;
      bright_floor_q <= sbfph_pkg::RST_BRIGHT_FLOOR;
      slow_w_q       <= sbfph_pkg::RST_SLOW_W;
      fast_w_q       <= sbfph_pkg::RST_FAST_W;
      flash_ratio_q  <= sbfph_pkg::RST_FLASH_RATIO;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sbfph_pkg::CFG_NOISE_THR:    noise_thr_q    <= cfg_wdata_i[7:0];
        sbfph_pkg::CFG_BAR_DECAY:    bar_decay_q    <= cfg_wdata_i[7:0];
        sbfph_pkg::CFG_BRIGHT_DECAY: bright_decay_q <= cfg_wdata_i[7:0];
        sbfph_pkg::CFG_BRIGHT_FLOOR: bright_floor_q <= cfg_wdata_i[7:0];
        sbfph_pkg::CFG_SLOW_W:       slow_w_q       <= cfg_wdata_i;
        sbfph_pkg::CFG_FAST_W:       fast_w_q       <= cfg_wdata_i;
        sbfph_pkg::CFG_FLASH_RATIO:  flash_ratio_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer
  sbfph_pkg::seq_ctrl_t ctrl;
  logic slot_free, bin_low, bin_last;
  logic out_valid_q;
  sbfph_pkg::out_item_t out_q, out_d;

  logic [7:0] mag_q;
  logic [4:0] bin_q;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign bin_low   = (bin_q < sbfph_pkg::FIRST_BAR_BIN);
  assign bin_last  = (bin_q == LastBin);

  sbfph_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .slot_free_i (slot_free),
    .bin_low_i   (bin_low),
    .bin_last_i  (bin_last),
    .ctrl_o      (ctrl)
  );

  assign in_stall_o = !ctrl.in_ready;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ctrl.in_ready) begin
      mag_q <= in_data_i.magnitude;
      bin_q <= in_data_i.bin_index;
    end
  end

  // bin update
  logic [7:0] bar_hold_q [NUM_BARS];
  logic [7:0] band_peak_q [sbfph_pkg::NUM_BANDS];
  logic [7:0] frame_peak_q;
  logic [7:0] mag_thr, hold_old, hold_max, hold_new;
  logic [4:0] bar_idx;
  logic [1:0] band_sel;

  assign mag_thr  = (mag_q < noise_thr_q) ? 8'd0 : mag_q;
  assign bar_idx  = bin_q - sbfph_pkg::FIRST_BAR_BIN;
  assign band_sel = (bin_q < sbfph_pkg::MID_START)  ? 2'd0 :
                    (bin_q < sbfph_pkg::HIGH_START) ? 2'd1 : 2'd2;
  assign hold_old = bar_hold_q[bar_idx[BarIdxW-1:0]];
  assign hold_max = (mag_thr > hold_old) ? mag_thr : hold_old;
  assign hold_new = (hold_max > bar_decay_q) ? hold_max - bar_decay_q : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BARS; i++) bar_hold_q[i] <= '0;
    end else if (ctrl.push_bar) begin
      bar_hold_q[bar_idx[BarIdxW-1:0]] <= hold_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbfph_pkg::NUM_BANDS; i++) band_peak_q[i] <= '0;
      frame_peak_q <= '0;
    end else if (ctrl.bin_en) begin
      if (bin_q == '0) begin
        for (int i = 0; i < sbfph_pkg::NUM_BANDS; i++) band_peak_q[i] <= '0;
        frame_peak_q <= '0;
      end else if (ctrl.push_bar) begin
        if (mag_thr > band_peak_q[band_sel]) band_peak_q[band_sel] <= mag_thr;
        if (mag_thr > frame_peak_q) frame_peak_q <= mag_thr;
      end
    end
  end

  // frame-end jobs on the shared unit
  logic [23:0] slow_avg_q [sbfph_pkg::NUM_BANDS];
  logic [23:0] fast_avg_q [sbfph_pkg::NUM_BANDS];
  logic [23:0] peak_avg_q;
  logic [7:0]  bright_q [sbfph_pkg::NUM_BANDS];

  sbfph_pkg::job_t    jd;
  sbfph_pkg::mac_op_t mac_op;
  logic [sbfph_pkg::MAC_A_W-1:0] mac_a;
  logic [sbfph_pkg::MAC_B_W-1:0] mac_b;
  logic [sbfph_pkg::PROD_W-1:0]  mac_prod;
  logic [sbfph_pkg::SUM_W-1:0]   mac_sum;
  logic [23:0] avg_sel;
  logic [15:0] w_sel;
  logic [7:0]  x_sel, peak_floored;
  logic        ema_write, flash_step, flash;
  logic [7:0]  br_set, br_dec, br_new;

  assign jd = sbfph_pkg::job_decode(ctrl.job);
  assign peak_floored = (frame_peak_q < sbfph_pkg::PEAK_FLOOR) ?
                        sbfph_pkg::PEAK_FLOOR : frame_peak_q;

  always_comb begin
    unique case (jd.kind)
      sbfph_pkg::JOB_PEAK_EMA: begin
        avg_sel = peak_avg_q;
        w_sel   = slow_w_q;
        x_sel   = peak_floored;
      end
      sbfph_pkg::JOB_SLOW_EMA: begin
        avg_sel = slow_avg_q[jd.band];
        w_sel   = slow_w_q;
        x_sel   = band_peak_q[jd.band];
      end
      sbfph_pkg::JOB_FAST_EMA: begin
        avg_sel = fast_avg_q[jd.band];
        w_sel   = fast_w_q;
        x_sel   = band_peak_q[jd.band];
      end
      default: begin
        avg_sel = slow_avg_q[jd.band];
        w_sel   = slow_w_q;
        x_sel   = band_peak_q[jd.band];
      end
    endcase
  end

  always_comb begin
    mac_op.mul_en = 1'b0;
    mac_op.acc_op = sbfph_pkg::ACC_HOLD;
    mac_a         = avg_sel;
    mac_b         = sbfph_pkg::ONE_Q16 - {1'b0, w_sel};
    if (jd.kind == sbfph_pkg::JOB_FLASH) begin
      mac_b         = {1'b0, flash_ratio_q};
      mac_op.mul_en = ctrl.ema_en && (ctrl.phase == 2'd0);
    end else if (ctrl.phase == 2'd0) begin
      mac_op.mul_en = ctrl.ema_en;
    end else if (ctrl.phase == 2'd1) begin
      mac_a         = sbfph_pkg::MAC_A_W'(x_sel);
      mac_b         = {1'b0, w_sel};
      mac_op.mul_en = ctrl.ema_en;
      mac_op.acc_op = ctrl.ema_en ? sbfph_pkg::ACC_ROUND : sbfph_pkg::ACC_HOLD;
    end
  end

  sbfph_mac u_mac (
    .clk_i  (clk_i),
    .op_i   (mac_op),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .prod_o (mac_prod),
    .sum_o  (mac_sum)
  );

  assign ema_write  = ctrl.ema_en && (jd.kind != sbfph_pkg::JOB_FLASH) &&
                      (ctrl.phase == sbfph_pkg::PHASE_EMA_LAST);
  assign flash_step = ctrl.ema_en && (jd.kind == sbfph_pkg::JOB_FLASH) &&
                      (ctrl.phase == sbfph_pkg::PHASE_FLASH_LAST);
  assign flash  = sbfph_pkg::PROD_W'({fast_avg_q[jd.band], 8'd0}) > mac_prod;
  assign br_set = flash ? sbfph_pkg::FLASH_LEVEL : bright_q[jd.band];
  assign br_dec = (br_set > bright_decay_q) ? br_set - bright_decay_q : 8'd0;
  assign br_new = (br_dec < bright_floor_q) ? bright_floor_q : br_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbfph_pkg::NUM_BANDS; i++) begin
        slow_avg_q[i] <= '0;
        fast_avg_q[i] <= '0;
        bright_q[i]   <= '0;
      end
      peak_avg_q <= '0;
    end else begin
      if (ema_write) begin
        unique case (jd.kind)
          sbfph_pkg::JOB_PEAK_EMA: peak_avg_q <= mac_sum[23:0];
          sbfph_pkg::JOB_SLOW_EMA: slow_avg_q[jd.band] <= mac_sum[23:0];
          sbfph_pkg::JOB_FAST_EMA: fast_avg_q[jd.band] <= mac_sum[23:0];
          default: ;
        endcase
      end
      if (flash_step) bright_q[jd.band] <= br_new;
    end
  end

  // output register
  always_comb begin
    out_d = '0;
    if (ctrl.push_sum) begin
      out_d.kind          = sbfph_pkg::KIND_SUMMARY;
      out_d.bright_low    = bright_q[0];
      out_d.bright_mid    = bright_q[1];
      out_d.bright_high   = bright_q[2];
      out_d.max_level_avg = peak_avg_q[23:16];
      out_d.last          = 1'b1;
    end else begin
      out_d.kind      = sbfph_pkg::KIND_BAR;
      out_d.bar_index = bar_idx;
      out_d.bar_level = hold_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.push_bar || ctrl.push_sum) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.push_bar || ctrl.push_sum) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "accepted item did not make block busy")
  `ASSERT_IMPLIES(a_push_needs_slot, clk_i, rst_ni, ctrl.push_bar || ctrl.push_sum, slot_free, "result pushed over a waiting item")
  `ASSERT_IMPLIES(a_ema_exclusive, clk_i, rst_ni, ctrl.ema_en, in_stall_o && !ctrl.push_bar && !ctrl.bin_en, "frame-end job overlaps bin work")
  `ASSERT_IMPLIES(a_bar_range, clk_i, rst_ni, out_valid_o && !out_data_o.kind, out_data_o.bar_index < 5'(NUM_BARS), "bar index out of range")

endmodule

// ===== dv/tb_spectrum_band_flash_peak_hold.sv =====
// Self-checking bench for spectrum_band_flash_peak_hold: directed bins, then random frames
// under several register settings, each result checked against an in-bench predictor or a typed-in bar level.
// Depends on sbfph_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_spectrum_band_flash_peak_hold;

  localparam logic [4:0] LAST_BIN   = 5'd31;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam int SETTLE_CYC = 40;
  localparam int PHASE_ITEMS = 215;
  localparam int NUM_PHASES = 6;

  typedef struct packed {
    logic [7:0] mag;
    logic [4:0] bin;
    logic       typed;
    logic [7:0] lvl;
  } dir_row_t;

  // bar level typed in where it is obvious; zero level rows with typed=0 go to the predictor
  localparam dir_row_t DIR_ROWS [18] = '{
    '{8'd255, 5'd0,  1'b0, 8'd0},
    '{8'd255, 5'd1,  1'b0, 8'd0},
    '{8'd255, 5'd2,  1'b1, 8'd253},
    '{8'd0,   5'd3,  1'b1, 8'd0},
    '{8'd49,  5'd4,  1'b1, 8'd0},
    '{8'd50,  5'd5,  1'b1, 8'd48},
    '{8'd1,   5'd6,  1'b1, 8'd0},
    '{8'd200, 5'd10, 1'b1, 8'd198},
    '{8'd255, 5'd11, 1'b1, 8'd253},
    '{8'd100, 5'd30, 1'b1, 8'd98},
    '{8'd255, 5'd31, 1'b0, 8'd0},
    '{8'd255, 5'd2,  1'b1, 8'd253},
    '{8'd0,   5'd2,  1'b1, 8'd251},
    '{8'd0,   5'd31, 1'b1, 8'd251},
    '{8'd7,   5'd0,  1'b0, 8'd0},
    '{8'd0,   5'd31, 1'b1, 8'd249},
    '{8'd128, 5'd7,  1'b0, 8'd0},
    '{8'd51,  5'd31, 1'b1, 8'd247}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  sbfph_pkg::in_item_t   in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sbfph_pkg::out_item_t  out_data;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_idx = '0;
  logic [15:0]           cfg_wdata = '0;

  spectrum_band_flash_peak_hold uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // predictor state and register copies
  logic [7:0]  thr_r = sbfph_pkg::RST_NOISE_THR, bar_step_r = sbfph_pkg::RST_BAR_DECAY;
  logic [7:0]  bright_step_r = sbfph_pkg::RST_BRIGHT_DECAY;
  logic [7:0]  bright_flr_r = sbfph_pkg::RST_BRIGHT_FLOOR;
  logic [15:0] w_slow_r = sbfph_pkg::RST_SLOW_W, w_fast_r = sbfph_pkg::RST_FAST_W;
  logic [15:0] ratio_r = sbfph_pkg::RST_FLASH_RATIO;
  logic [29:0][7:0] hold_m = '0;
  logic [2:0][7:0]  band_pk_m = '0, bright_m = '0;
  logic [7:0]       frame_pk_m = '0;
  logic [2:0][23:0] slow_m = '0, fast_m = '0;
  logic [23:0]      peak_slow_m = '0;

  sbfph_pkg::out_item_t pending_out[$];
  int err_cnt = 0;
  int sent_cnt = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("tb_spectrum_band_flash_peak_hold: done, errors");
    $finish;
  end

  function automatic logic [23:0] ema_q16(logic [23:0] avg, logic [7:0] x, logic [15:0] w);
    logic [63:0] s;
    s = 64'(x) * 64'd65536 * 64'(w) + 64'(avg) * (64'd65536 - 64'(w)) + 64'd32768;
    return s[39:16];
  endfunction

  // one bin through the bars, band peaks and (on the last bin) the frame-end averages
  function automatic int bin_update(sbfph_pkg::in_item_t it,
                                    output sbfph_pkg::out_item_t bar_r,
                                    output sbfph_pkg::out_item_t sum_r);
    logic [7:0] mag, h, pk, b;
    logic [4:0] bin;
    int band;
    bar_r = '0;
    sum_r = '0;
    mag = (it.magnitude < thr_r) ? 8'd0 : it.magnitude;
    bin = it.bin_index;
    if (bin == 5'd0) begin
      band_pk_m = '0;
      frame_pk_m = '0;
    end
    if (bin < sbfph_pkg::FIRST_BAR_BIN) return 0;
    band = (bin < sbfph_pkg::MID_START) ? 0 : (bin < sbfph_pkg::HIGH_START) ? 1 : 2;
    if (mag > band_pk_m[band]) band_pk_m[band] = mag;
    if (mag > frame_pk_m) frame_pk_m = mag;
    h = hold_m[bin - sbfph_pkg::FIRST_BAR_BIN];
    if (mag > h) h = mag;
    h = (h > bar_step_r) ? h - bar_step_r : 8'd0;
    hold_m[bin - sbfph_pkg::FIRST_BAR_BIN] = h;
    bar_r.kind = sbfph_pkg::KIND_BAR;
    bar_r.bar_index = bin - sbfph_pkg::FIRST_BAR_BIN;
    bar_r.bar_level = h;
    if (bin != LAST_BIN) return 1;
    pk = (frame_pk_m < sbfph_pkg::PEAK_FLOOR) ? sbfph_pkg::PEAK_FLOOR : frame_pk_m;
    peak_slow_m = ema_q16(peak_slow_m, pk, w_slow_r);
    for (int k = 0; k < sbfph_pkg::NUM_BANDS; k++) begin
      slow_m[k] = ema_q16(slow_m[k], band_pk_m[k], w_slow_r);
      fast_m[k] = ema_q16(fast_m[k], band_pk_m[k], w_fast_r);
      b = bright_m[k];
      if (64'(fast_m[k]) * 64'd256 > 64'(slow_m[k]) * 64'(ratio_r))
        b = sbfph_pkg::FLASH_LEVEL;
      b = (b > bright_step_r) ? b - bright_step_r : 8'd0;
      if (b < bright_flr_r) b = bright_flr_r;
      bright_m[k] = b;
    end
    sum_r.kind = sbfph_pkg::KIND_SUMMARY;
    sum_r.bright_low = bright_m[0];
    sum_r.bright_mid = bright_m[1];
    sum_r.bright_high = bright_m[2];
    sum_r.max_level_avg = peak_slow_m[23:16];
    sum_r.last = 1'b1;
    return 2;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] e, logic [63:0] g);
    err_cnt++;
    if (err_cnt <= 50)
      $display("%0t mismatch %s: expected %0h got %0h", $time, what, e, g);
  endtask

  task automatic check_field(string name, logic [7:0] e, logic [7:0] g);
    if (g !== e) report_mismatch(name, e, g);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_bin(logic [7:0] mag, logic [4:0] bin, logic typed = 1'b0,
                          logic [7:0] lvl = 8'd0);
    sbfph_pkg::in_item_t it;
    sbfph_pkg::out_item_t r0, r1;
    int n;
    it = '{magnitude: mag, bin_index: bin};
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = bin_update(it, r0, r1);
    if (typed) r0.bar_level = lvl;
    if (n > 0) pending_out.push_back(r0);
    if (n > 1) pending_out.push_back(r1);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      sbfph_pkg::CFG_NOISE_THR:    thr_r = data[7:0];
      sbfph_pkg::CFG_BAR_DECAY:    bar_step_r = data[7:0];
      sbfph_pkg::CFG_BRIGHT_DECAY: bright_step_r = data[7:0];
      sbfph_pkg::CFG_BRIGHT_FLOOR: bright_flr_r = data[7:0];
      sbfph_pkg::CFG_SLOW_W:       w_slow_r = data;
      sbfph_pkg::CFG_FAST_W:       w_fast_r = data;
      sbfph_pkg::CFG_FLASH_RATIO:  ratio_r = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // 8-bit registers get junk in the upper byte of the write data
  task automatic program_regs(logic [7:0] thr, logic [7:0] bar_step, logic [7:0] br_step,
                              logic [7:0] br_floor, logic [15:0] w_slow,
                              logic [15:0] w_fast, logic [15:0] ratio);
    cfg_write(sbfph_pkg::CFG_NOISE_THR, {8'($urandom), thr});
    cfg_write(sbfph_pkg::CFG_BAR_DECAY, {8'($urandom), bar_step});
    cfg_write(sbfph_pkg::CFG_BRIGHT_DECAY, {8'($urandom), br_step});
    cfg_write(sbfph_pkg::CFG_BRIGHT_FLOOR, {8'($urandom), br_floor});
    cfg_write(sbfph_pkg::CFG_SLOW_W, w_slow);
    cfg_write(sbfph_pkg::CFG_FAST_W, w_fast);
    cfg_write(sbfph_pkg::CFG_FLASH_RATIO, ratio);
    cfg_write(CFG_UNUSED, 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_mag(logic [7:0] loud);
    logic [8:0] t;
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: begin
        t = 9'(thr_r) + 9'($urandom_range(0, 2));
        t = (t == 9'd0) ? 9'd0 : t - 9'd1;
        return (t > 9'd255) ? 8'd255 : t[7:0];
      end
      default: return 8'($urandom_range(0, loud));
    endcase
  endfunction

  always @(negedge clk) out_stall <= ($urandom_range(0, 99) < sink_stall_pct);

  always @(posedge clk) begin : result_check
    sbfph_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_out.size() == 0) begin
        report_mismatch("result with nothing pending", 64'd0, 64'(out_data));
      end else begin
        want = pending_out.pop_front();
        check_field("kind", 8'(want.kind), 8'(out_data.kind));
        check_field("bar_index", 8'(want.bar_index), 8'(out_data.bar_index));
        check_field("bar_level", want.bar_level, out_data.bar_level);
        check_field("bright_low", want.bright_low, out_data.bright_low);
        check_field("bright_mid", want.bright_mid, out_data.bright_mid);
        check_field("bright_high", want.bright_high, out_data.bright_high);
        check_field("max_level_avg", want.max_level_avg, out_data.max_level_avg);
        check_field("last", 8'(want.last), 8'(out_data.last));
      end
    end
  end

  initial begin
    int pick, last_bin;
    logic [7:0] loud;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      src_idle_pct   = (p < 2) ? 11 : (p < 4) ? 73 : 0;
      sink_stall_pct = (p < 2) ? 73 : (p < 4) ? 11 : 0;
      if (p > 0) begin
        while (pending_out.size() != 0) @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
        case (p)
          1: program_regs(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd0, 16'd0);
          2: program_regs(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
          3: program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom), 16'($urandom), 16'($urandom));
          4: program_regs(8'd20, 8'd1, 8'd40, 8'd0, 16'd2000, 16'd60000, 16'd300);
          default: program_regs(8'($urandom_range(0, 60)), 8'($urandom_range(0, 6)),
                                8'($urandom_range(0, 60)), 8'($urandom_range(0, 80)),
                                16'($urandom_range(100, 8000)),
                                16'($urandom_range(20000, 65535)),
                                16'($urandom_range(256, 600)));
        endcase
        @(negedge clk);
      end else begin
        foreach (DIR_ROWS[i])
          send_bin(DIR_ROWS[i].mag, DIR_ROWS[i].bin, DIR_ROWS[i].typed, DIR_ROWS[i].lvl);
      end

      // mostly whole frames, some cut short, some stray bins
      while (sent_cnt < (p + 1) * PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        loud = 8'($urandom_range(0, 255));
        if (pick < 8) begin
          last_bin = (pick == 7) ? $urandom_range(0, 30) : 31;
          for (int b = 0; b <= last_bin; b++) send_bin(rand_mag(loud), 5'(b));
        end else begin
          repeat ($urandom_range(1, 8)) send_bin(rand_mag(loud), 5'($urandom_range(0, 31)));
        end
      end
      in_valid <= 1'b0;
    end

    while (pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (pending_out.size() != 0)
      report_mismatch("results never arrived", 64'd0, 64'(pending_out.size()));
    if (err_cnt == 0) begin
      $display("tb_spectrum_band_flash_peak_hold: done, clean");
    end else begin
      $display("tb_spectrum_band_flash_peak_hold: done, errors");
    end
    $finish;
  end

endmodule
